### design/qmlr_pkg.sv
// qmlr_pkg: sizes, codes, tables and shared types of the quadratic mixture
// log response block. No dependencies; qmlr_store and the top level import it.
package qmlr_pkg;

  localparam int MAX_NONLINEAR  = 16;
  localparam int MAX_LINEAR     = 8;
  localparam int MAX_COMPONENTS = 8;
  localparam int MAX_FEATURES   = 16;
  localparam int BUF_DEPTH      = MAX_NONLINEAR + MAX_LINEAR;

  localparam int NL_W   = $clog2(MAX_NONLINEAR);
  localparam int LN_W   = $clog2(MAX_LINEAR);
  localparam int CMP_W  = $clog2(MAX_COMPONENTS);
  localparam int FT_W   = $clog2(MAX_FEATURES);
  localparam int BUF_W  = $clog2(BUF_DEPTH);
  localparam int ADDR_W = NL_W + FT_W;
  localparam int SUM_W  = 17 + $clog2(MAX_COMPONENTS);
  localparam int LE_W   = 5;
  localparam int L2_W   = LE_W + 16;

  // commands
  localparam logic [2:0] CMD_BIAS      = 3'd0;
  localparam logic [2:0] CMD_WEIGHT    = 3'd1;
  localparam logic [2:0] CMD_FEATURE   = 3'd2;
  localparam logic [2:0] CMD_PREDICTOR = 3'd3;
  localparam logic [2:0] CMD_LINEAR    = 3'd4;
  localparam logic [2:0] CMD_PUSH      = 3'd5;

  // configuration register indexes
  localparam logic [3:0] REG_NONLINEAR = 4'd0;
  localparam logic [3:0] REG_LINEAR    = 4'd1;
  localparam logic [3:0] REG_COMPONENT = 4'd2;
  localparam logic [3:0] REG_FEATURE   = 4'd3;

  // table selected by a streaming loop
  localparam int PH_W = 3;
  localparam logic [PH_W-1:0] PH_PROJ = 3'd0;
  localparam logic [PH_W-1:0] PH_BIAS = 3'd1;
  localparam logic [PH_W-1:0] PH_WGT  = 3'd2;
  localparam logic [PH_W-1:0] PH_PRED = 3'd3;
  localparam logic [PH_W-1:0] PH_LIN  = 3'd4;

  localparam logic signed [31:0] ONE_Q   = 32'sd65536;
  localparam logic signed [31:0] LOG2E_Q = 32'sd94548;
  localparam logic signed [31:0] LN2_Q   = 32'sd45426;

  typedef struct packed {
    logic              valid;
    logic [2:0]        command;
    logic [4:0]        row_index;
    logic [3:0]        col_index;
    logic signed [31:0] value;
  } wr_req_t;

  typedef struct packed {
    logic              valid;
    logic [PH_W-1:0]   tbl;
    logic [ADDR_W-1:0] a_addr;
    logic [BUF_W-1:0]  x_addr;
  } rd_req_t;

  function automatic logic [16:0] pow_tab(input logic [4:0] j);
    logic [16:0] v;
    case (j)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd62757;
      5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549;
      5'd4:  v = 17'd55109;
      5'd5:  v = 17'd52773;
      5'd6:  v = 17'd50535;
      5'd7:  v = 17'd48393;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

  function automatic logic [16:0] log_tab(input logic [4:0] j);
    logic [16:0] v;
    case (j)
      5'd0:  v = 17'd0;
      5'd1:  v = 17'd5732;
      5'd2:  v = 17'd11136;
      5'd3:  v = 17'd16248;
      5'd4:  v = 17'd21098;
      5'd5:  v = 17'd25711;
      5'd6:  v = 17'd30109;
      5'd7:  v = 17'd34312;
      5'd8:  v = 17'd38336;
      5'd9:  v = 17'd42196;
      5'd10: v = 17'd45904;
      5'd11: v = 17'd49472;
      5'd12: v = 17'd52911;
      5'd13: v = 17'd56229;
      5'd14: v = 17'd59434;
      5'd15: v = 17'd62534;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage

### design/qmlr_in_if.sv
// qmlr_in_if: input item channel, command plus table or element payload.
// Stands alone; widths follow the item fields.
interface qmlr_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        command;
  logic [4:0]        row_index;
  logic [3:0]        col_index;
  logic signed [31:0] value;
  logic              last_element;

  modport source (output valid, command, row_index, col_index, value, last_element,
                  input ready);
  modport sink (input valid, command, row_index, col_index, value, last_element,
                output ready);
endinterface

### design/qmlr_out_if.sv
// qmlr_out_if: result channel carrying the saturated response.
// Stands alone.
interface qmlr_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] response;
  logic              saturated;

  modport source (output valid, response, saturated, input ready);
  modport sink (input valid, response, saturated, output ready);
endinterface

### design/qmlr_cfg_if.sv
// qmlr_cfg_if: configuration write channel, register index and data.
// Stands alone.
interface qmlr_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/qmlr_store.sv
// qmlr_store: model tables and input element buffer, one write to one table
// and one registered read per table each cycle. Depends on qmlr_pkg.
module qmlr_store (
  input  logic                    clk,
  input  logic                    rst,
  input  qmlr_pkg::wr_req_t       wr,
  input  qmlr_pkg::rd_req_t       rd,
  output logic                    rd_valid,
  output logic signed [31:0]      rd_a,
  output logic signed [31:0]      rd_x
);
  import qmlr_pkg::*;

  logic signed [31:0] bias_mem [MAX_COMPONENTS];
  logic signed [31:0] weight_mem [MAX_COMPONENTS*MAX_FEATURES];
  logic signed [31:0] feature_mem [MAX_NONLINEAR*MAX_FEATURES];
  logic signed [31:0] pred_mem [MAX_COMPONENTS*MAX_NONLINEAR];
  logic signed [31:0] lin_mem [MAX_LINEAR];
  logic signed [31:0] buf_mem [BUF_DEPTH];

  logic signed [31:0] bias_q, weight_q, feature_q, pred_q, lin_q;
  logic [PH_W-1:0]    sel_q;

  always_ff @(posedge clk) begin
    if (wr.valid) begin
      case (wr.command)
        CMD_BIAS: begin
          if (wr.row_index < 5'(MAX_COMPONENTS))
            bias_mem[wr.row_index[CMP_W-1:0]] <= wr.value;
        end
        CMD_WEIGHT: begin
          if (wr.row_index < 5'(MAX_COMPONENTS))
            weight_mem[{wr.row_index[CMP_W-1:0], wr.col_index[FT_W-1:0]}] <= wr.value;
        end
        CMD_FEATURE: begin
          if (wr.row_index < 5'(MAX_NONLINEAR))
            feature_mem[{wr.row_index[NL_W-1:0], wr.col_index[FT_W-1:0]}] <= wr.value;
        end
        CMD_PREDICTOR: begin
          if (wr.row_index < 5'(MAX_COMPONENTS))
            pred_mem[{wr.row_index[CMP_W-1:0], wr.col_index[NL_W-1:0]}] <= wr.value;
        end
        CMD_LINEAR: begin
          if (wr.row_index < 5'(MAX_LINEAR))
            lin_mem[wr.row_index[LN_W-1:0]] <= wr.value;
        end
        CMD_PUSH: begin
          if (wr.row_index < 5'(BUF_DEPTH))
            buf_mem[wr.row_index[BUF_W-1:0]] <= wr.value;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    bias_q    <= bias_mem[rd.a_addr[CMP_W-1:0]];
    weight_q  <= weight_mem[rd.a_addr[CMP_W+FT_W-1:0]];
    feature_q <= feature_mem[rd.a_addr];
    pred_q    <= pred_mem[rd.a_addr[CMP_W+NL_W-1:0]];
    lin_q     <= lin_mem[rd.a_addr[LN_W-1:0]];
    rd_x      <= buf_mem[rd.x_addr];
    sel_q     <= rd.tbl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd.valid;
    end
  end

  always_comb begin
    case (sel_q)
      PH_PROJ: rd_a = feature_q;
      PH_BIAS: rd_a = bias_q;
      PH_WGT:  rd_a = weight_q;
      PH_PRED: rd_a = pred_q;
      PH_LIN:  rd_a = lin_q;
      default: rd_a = '0;
    endcase
  end

endmodule

### design/qmlr_mul.sv
// qmlr_mul: shared signed 32x32 multiplier with a registered product.
// Depends on no other file; used by the sequencer for every product.
module qmlr_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               out_valid,
  output logic signed [63:0] prod
);

  always_ff @(posedge clk) begin
    prod <= 64'(a) * 64'(b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

endmodule

### design/quadratic_mixture_log_response.sv
// quadratic_mixture_log_response: top level, sequencer around the shared
// multiplier and the table store. Depends on qmlr_pkg, the channel
// interfaces, qmlr_store and qmlr_mul.
//
// Usage. Items on the item channel either write a table word (bias, weight,
// feature, predictor, linear coefficient) or push one input element. Table
// writes and pushes without last_element are taken whenever the block is idle.
// A push with last_element starts the evaluation; item.ready stays low until
// the result is in the output register. The user is to write registers on
// the cfg channel only while the block is idle; the block does not enforce
// it. cfg.ready is always high. Every product of an evaluation goes through
// the one multiplier, streamed one per cycle inside a loop, and each loop
// drains its table reads and products before it ends. Exp and log take two
// products each plus up to three normalizing shifts.
// Reset clears the registers to their defaults and the control; table
// contents are undefined until written. The result waits in the output
// register while the receiver stalls; the next table writes are taken
// meanwhile, and a further evaluation holds at its end until that register
// is free.
module quadratic_mixture_log_response (
  input  logic      clk,
  input  logic      rst,
  qmlr_in_if.sink   item,
  qmlr_out_if.source result,
  qmlr_cfg_if.sink  cfg
);
  import qmlr_pkg::*;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
  localparam logic [ST_W-1:0] S_LOOP   = 4'd1;
  localparam logic [ST_W-1:0] S_SQ     = 4'd2;
  localparam logic [ST_W-1:0] S_SQ_W   = 4'd3;
  localparam logic [ST_W-1:0] S_EXP0   = 4'd4;
  localparam logic [ST_W-1:0] S_EXP1_W = 4'd5;
  localparam logic [ST_W-1:0] S_EXP2   = 4'd6;
  localparam logic [ST_W-1:0] S_EXP2_W = 4'd7;
  localparam logic [ST_W-1:0] S_LOG0   = 4'd8;
  localparam logic [ST_W-1:0] S_LOG_N  = 4'd9;
  localparam logic [ST_W-1:0] S_LOG1   = 4'd10;
  localparam logic [ST_W-1:0] S_LOG1_W = 4'd11;
  localparam logic [ST_W-1:0] S_LOG2   = 4'd12;
  localparam logic [ST_W-1:0] S_LOG2_W = 4'd13;
  localparam logic [ST_W-1:0] S_FIN0   = 4'd14;
  localparam logic [ST_W-1:0] S_FIN    = 4'd15;

  localparam logic signed [63:0] EXP_FLOOR = -64'sd1572864;
  localparam logic signed [63:0] EXP_CEIL  = 64'sd2097152;
  localparam logic signed [63:0] Q_MAX     = 64'sd2147483647;
  localparam logic signed [63:0] Q_MIN     = -64'sd2147483648;

  logic [ST_W-1:0]     state;
  logic [PH_W-1:0]     phase;
  logic [4:0]          cnt, len;
  logic [4:0]          f;
  logic [3:0]          k;
  logic [4:0]          nl_len, fc;
  logic [3:0]          ll, kc;
  logic signed [63:0]  acc, m;
  logic signed [63:0]  energy [MAX_COMPONENTS];
  logic [30:0]         psq [MAX_FEATURES];
  logic [30:0]         psq_rd;
  logic [20:0]         tq;
  logic [SUM_W-1:0]    sum, lsum;
  logic [LE_W-1:0]     le;
  logic [L2_W-1:0]     l2, lnv;
  logic                res_valid;
  logic signed [31:0]  res_value;
  logic                res_sat;

  wr_req_t             wr;
  rd_req_t             rd;
  logic                rd_valid;
  logic signed [31:0]  rd_a, rd_x;
  logic                mul_in_valid, mul_valid;
  logic signed [31:0]  mul_a, mul_b;
  logic signed [63:0]  prod, prod_q;

  logic                issue, loop_done, sc_go;
  logic signed [31:0]  sc_a, sc_b, loop_b, sq_op;
  logic signed [63:0]  d, tneg, tot;
  logic [4:0]          tj, lj;
  logic [16:0]         ex_v;
  logic [4:0]          v5;
  logic [3:0]          v4;

  assign item.ready   = (state == S_IDLE);
  assign cfg.ready    = 1'b1;
  assign result.valid = res_valid;
  assign result.response  = res_value;
  assign result.saturated = res_sat;

  assign v5 = cfg.data[4:0];
  assign v4 = cfg.data[3:0];

  always_comb begin
    wr.valid     = item.valid && item.ready;
    wr.command   = item.command;
    wr.row_index = item.row_index;
    wr.col_index = item.col_index;
    wr.value     = item.value;
  end

  qmlr_store u_store (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd       (rd),
    .rd_valid (rd_valid),
    .rd_a     (rd_a),
    .rd_x     (rd_x)
  );

  qmlr_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_in_valid),
    .a         (mul_a),
    .b         (mul_b),
    .out_valid (mul_valid),
    .prod      (prod)
  );

  assign prod_q = prod >>> 16;

  always_comb begin
    case (phase)
      PH_PROJ: len = nl_len;
      PH_BIAS: len = 5'd1;
      PH_WGT:  len = fc;
      PH_PRED: len = nl_len;
      PH_LIN:  len = 5'(ll);
      default: len = '0;
    endcase
  end

  assign issue     = (state == S_LOOP) && (cnt != len);
  assign loop_done = (state == S_LOOP) && (cnt == len) && !rd_valid && !mul_valid;

  always_comb begin
    rd.valid  = issue;
    rd.tbl    = phase;
    rd.x_addr = BUF_W'(cnt);
    case (phase)
      PH_PROJ: rd.a_addr = {cnt[NL_W-1:0], f[FT_W-1:0]};
      PH_BIAS: rd.a_addr = ADDR_W'(k[CMP_W-1:0]);
      PH_WGT:  rd.a_addr = ADDR_W'({k[CMP_W-1:0], cnt[FT_W-1:0]});
      PH_PRED: rd.a_addr = ADDR_W'({k[CMP_W-1:0], cnt[NL_W-1:0]});
      PH_LIN: begin
        rd.a_addr = ADDR_W'(cnt[LN_W-1:0]);
        rd.x_addr = BUF_W'(nl_len) + BUF_W'(cnt);
      end
      default: rd.a_addr = '0;
    endcase
  end

  always_comb begin
    case (phase)
      PH_BIAS: loop_b = ONE_Q;
      PH_WGT:  loop_b = {1'b0, psq_rd};
      default: loop_b = rd_x;
    endcase
  end

  // projection clamp before squaring
  always_comb begin
    if (acc > Q_MAX)      sq_op = 32'sh7FFFFFFF;
    else if (acc < Q_MIN) sq_op = 32'sh80000000;
    else                  sq_op = acc[31:0];
  end

  assign d    = energy[k[CMP_W-1:0]] - m;
  assign tneg = -prod_q;
  assign tj   = {1'b0, tq[15:12]};
  assign lj   = {1'b0, lsum[15:12]};
  assign ex_v = pow_tab(tj) - 17'(prod[63:12]);
  assign tot  = m + acc;

  always_comb begin
    sc_go = 1'b0;
    sc_a  = '0;
    sc_b  = '0;
    case (state)
      S_SQ: begin
        sc_go = 1'b1;
        sc_a  = sq_op;
        sc_b  = sq_op;
      end
      S_EXP0: begin
        sc_go = !(d <= EXP_FLOOR);
        sc_a  = d[31:0];
        sc_b  = LOG2E_Q;
      end
      S_EXP2: begin
        sc_go = 1'b1;
        sc_a  = 32'(pow_tab(tj) - pow_tab(tj + 5'd1));
        sc_b  = 32'(tq[11:0]);
      end
      S_LOG1: begin
        sc_go = 1'b1;
        sc_a  = 32'(log_tab(lj + 5'd1) - log_tab(lj));
        sc_b  = 32'(lsum[11:0]);
      end
      S_LOG2: begin
        sc_go = 1'b1;
        sc_a  = 32'(l2);
        sc_b  = LN2_Q;
      end
      default: ;
    endcase
  end

  assign mul_in_valid = rd_valid || sc_go;
  assign mul_a        = sc_go ? sc_a : rd_a;
  assign mul_b        = sc_go ? sc_b : loop_b;

  always_ff @(posedge clk) begin
    if (issue) psq_rd <= psq[cnt[FT_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_PROJ;
      cnt       <= '0;
      f         <= '0;
      k         <= '0;
      nl_len    <= 5'(MAX_NONLINEAR);
      ll        <= '0;
      kc        <= 4'd1;
      fc        <= 5'(MAX_FEATURES);
      res_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_NONLINEAR: nl_len <= (v5 > 5'(MAX_NONLINEAR)) ? 5'(MAX_NONLINEAR) : v5;
          REG_LINEAR:    ll <= (v4 > 4'(MAX_LINEAR)) ? 4'(MAX_LINEAR) : v4;
          REG_COMPONENT: begin
            if (v4 == 4'd0)                     kc <= 4'd1;
            else if (v4 > 4'(MAX_COMPONENTS))   kc <= 4'(MAX_COMPONENTS);
            else                                kc <= v4;
          end
          REG_FEATURE:   fc <= (v5 > 5'(MAX_FEATURES)) ? 5'(MAX_FEATURES) : v5;
          default: ;
        endcase
      end

      if (result.ready) res_valid <= 1'b0;

      if (mul_valid && state == S_LOOP) acc <= acc + prod_q;

      case (state)
        S_IDLE: begin
          if (item.valid && item.command == CMD_PUSH && item.last_element) begin
            f     <= '0;
            k     <= '0;
            cnt   <= '0;
            acc   <= '0;
            phase <= (fc == 5'd0) ? PH_BIAS : PH_PROJ;
            state <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (issue) cnt <= cnt + 5'd1;
          if (loop_done) begin
            cnt <= '0;
            case (phase)
              PH_PROJ: state <= S_SQ;
              PH_BIAS: phase <= PH_WGT;
              PH_WGT:  phase <= PH_PRED;
              PH_PRED: begin
                energy[k[CMP_W-1:0]] <= acc;
                if (k == 4'd0 || acc > m) m <= acc;
                acc <= '0;
                if (k + 4'd1 < kc) begin
                  k     <= k + 4'd1;
                  phase <= PH_BIAS;
                end else begin
                  k     <= '0;
                  sum   <= '0;
                  state <= S_EXP0;
                end
              end
              PH_LIN:  state <= S_FIN0;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SQ: state <= S_SQ_W;
        S_SQ_W: begin
          if (mul_valid) begin
            psq[f[FT_W-1:0]] <= (prod_q > Q_MAX) ? 31'h7FFFFFFF : prod_q[30:0];
            acc   <= '0;
            cnt   <= '0;
            state <= S_LOOP;
            if (f + 5'd1 < fc) begin
              f     <= f + 5'd1;
              phase <= PH_PROJ;
            end else begin
              k     <= '0;
              phase <= PH_BIAS;
            end
          end
        end
        S_EXP0: begin
          if (d <= EXP_FLOOR) begin
            if (k + 4'd1 < kc) k <= k + 4'd1;
            else               state <= S_LOG0;
          end else begin
            state <= S_EXP1_W;
          end
        end
        S_EXP1_W: begin
          if (mul_valid) begin
            if (tneg >= EXP_CEIL) begin
              if (k + 4'd1 < kc) begin
                k     <= k + 4'd1;
                state <= S_EXP0;
              end else begin
                state <= S_LOG0;
              end
            end else begin
              tq    <= tneg[20:0];
              state <= S_EXP2;
            end
          end
        end
        S_EXP2: state <= S_EXP2_W;
        S_EXP2_W: begin
          if (mul_valid) begin
            sum <= sum + (SUM_W'(ex_v) >> tq[20:16]);
            if (k + 4'd1 < kc) begin
              k     <= k + 4'd1;
              state <= S_EXP0;
            end else begin
              state <= S_LOG0;
            end
          end
        end
        S_LOG0: begin
          lsum  <= sum;
          le    <= '0;
          state <= S_LOG_N;
        end
        // one shift a cycle until the sum lies below two
        S_LOG_N: begin
          if (lsum >= SUM_W'(2 * 65536)) begin
            lsum <= lsum >> 1;
            le   <= le + LE_W'(1);
          end else begin
            state <= S_LOG1;
          end
        end
        S_LOG1: state <= S_LOG1_W;
        S_LOG1_W: begin
          if (mul_valid) begin
            l2    <= {le, 16'd0} + L2_W'(log_tab(lj)) + L2_W'(prod[63:12]);
            state <= S_LOG2;
          end
        end
        S_LOG2: state <= S_LOG2_W;
        S_LOG2_W: begin
          if (mul_valid) begin
            lnv   <= prod[L2_W+15:16];
            acc   <= '0;
            cnt   <= '0;
            phase <= PH_LIN;
            state <= S_LOOP;
          end
        end
        S_FIN0: begin
          acc   <= acc + 64'(lnv);
          state <= S_FIN;
        end
        S_FIN: begin
          if (!res_valid || result.ready) begin
            res_valid <= 1'b1;
            if (tot > Q_MAX) begin
              res_value <= 32'sh7FFFFFFF;
              res_sat   <= 1'b1;
            end else if (tot < Q_MIN) begin
              res_value <= 32'sh80000000;
              res_sat   <= 1'b1;
            end else begin
              res_value <= tot[31:0];
              res_sat   <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_mul_source: assert property (@(posedge clk) disable iff (rst)
    mul_valid |-> $past(rd_valid || sc_go))
    else $error("product without an operand transfer");

  a_read_in_loop: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> $past(state) == S_LOOP)
    else $error("table read outside a loop");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_LOOP |-> cnt <= len)
    else $error("loop counter past its length");
`endif

endmodule
